// ----- hw/rtl/sjfbp_pkg.sv -----
// Shared types, constants and register codes of the SJF burst-prediction scheduler.
`timescale 1ns / 1ps
`default_nettype none
package sjfbp_pkg;
   localparam int NumTasks = 64;
   localparam int IdxW = $clog2(NumTasks);
   localparam int TimeW = 24;
   localparam int PrioW = 25;
   localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

   typedef enum logic [1:0] {
      EV_PUT  = 2'd0,
      EV_GET  = 2'd1,
      EV_TICK = 2'd2,
      EV_NONE = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      SM_PLAIN   = 2'd0,
      SM_PREEMPT = 2'd1,
      SM_EAGER   = 2'd2,
      SM_RSVD    = 2'd3
   } sched_mode_type;

   typedef enum logic [1:0] {
      REG_MODE   = 2'd0,
      REG_FACTOR = 2'd1,
      REG_SLICE  = 2'd2,
      REG_EASE   = 2'd3
   } reg_addr_type;

   typedef struct packed {
      logic [1:0] sched_mode;
      logic [7:0] avg_factor;
      logic [7:0] slice_ticks;
      logic [7:0] ease_bias;
   } cfg_type;

   typedef struct packed {
      logic [TimeW-1:0] tau;
      logic [PrioW-1:0] prio;
      logic [TimeW-1:0] ticks;
   } entry_type;
endpackage
`default_nettype wire

// ----- hw/rtl/sjfbp_blend.sv -----
// Exponential average, products registered then summed: (tau*(128-f) + t*f + 65) / 128.
`timescale 1ns / 1ps
`default_nettype none
module sjfbp_blend (
   input  wire logic                      clock,
   input  wire logic [7:0]                factor,
   input  wire logic [sjfbp_pkg::TimeW-1:0] tau,
   input  wire logic [sjfbp_pkg::TimeW-1:0] ticks,
   output logic [sjfbp_pkg::TimeW-1:0]      result
);
   import sjfbp_pkg::*;
   logic [7:0]        f_w;
   logic [TimeW+7:0]  pa_ff, pb_ff;
   logic [TimeW+8:0]  sum_w;

   assign f_w = (factor > 8'd128) ? 8'd128 : factor;

   always_ff @(posedge clock) begin
      pa_ff <= tau * (TimeW+8)'(8'd128 - f_w);
      pb_ff <= ticks * (TimeW+8)'(f_w);
   end

   assign sum_w = (TimeW+9)'(pa_ff) + (TimeW+9)'(pb_ff) + (TimeW+9)'(65);
   assign result = sum_w[TimeW+6:7];
endmodule
`default_nettype wire

// ----- hw/rtl/sjfbp_ctrl.sv -----
// Sequencer: reads, scans and writes back the task table memory.
`timescale 1ns / 1ps
`default_nettype none
module sjfbp_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire sjfbp_pkg::cfg_type           cfg,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [1:0]                  req_mode,
   input  wire logic [sjfbp_pkg::IdxW-1:0]  req_task_index,
   input  wire logic                        req_woke_up,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic                             rsp_task_valid,
   output logic [sjfbp_pkg::IdxW-1:0]       rsp_chosen_task,
   output logic                             rsp_preempt
);
   import sjfbp_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_BLEND, ST_WRITE, ST_SCAN, ST_DONE, ST_RESP
   } state_type;

   state_type state_ff, state_in;
   entry_type mem [NumTasks];
   entry_type rd_ff;
   entry_type rd_w;
   logic [NumTasks-1:0] wr_ff;
   logic            rd_wr_ff;
   logic [IdxW-1:0] addr_w;
   logic            we_w;
   entry_type       wd_w;

   logic [1:0]      ev_ff;
   logic [IdxW-1:0] idx_ff;
   logic            woke_ff;
   logic [NumTasks-1:0] mark_ff;
   logic [IdxW-1:0] cur_ff;
   logic            cur_valid_ff;
   logic [7:0]      slice_ff;
   logic [IdxW:0]   scan_ff;
   logic            best_valid_ff;
   logic [IdxW-1:0] best_idx_ff;
   logic [PrioW-1:0] best_prio_ff;
   logic [PrioW-1:0] cur_prio_ff;
   logic            check_ff;
   logic [TimeW-1:0] ticks_new_ff;
   logic            out_tv_ff, out_pre_ff;
   logic [IdxW-1:0] out_idx_ff;
   logic [TimeW-1:0] blend_w;
   logic [TimeW-1:0] blend_ticks_w;
   logic            scan_hit_w;
   logic [IdxW-1:0] scan_idx_w;

   sjfbp_blend u_blend (
      .clock (clock), .factor (cfg.avg_factor), .tau (rd_w.tau),
      .ticks (blend_ticks_w), .result (blend_w)
   );

   // entries never written read as zero
   assign rd_w = rd_wr_ff ? rd_ff : '0;
   assign blend_ticks_w = (ev_ff == EV_TICK) ? ticks_new_ff : rd_w.ticks;
   assign scan_idx_w = scan_ff[IdxW-1:0] - IdxW'(1);
   assign scan_hit_w = mark_ff[scan_idx_w] && (!best_valid_ff ||
                       $signed(rd_w.prio) < $signed(best_prio_ff));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_READ;
         ST_READ: begin
            unique case (ev_ff)
               EV_PUT:  state_in = woke_ff ? ST_BLEND : ST_WRITE;
               EV_GET:  state_in = ST_SCAN;
               EV_TICK: state_in = cur_valid_ff ? ST_BLEND : ST_RESP;
               default: state_in = ST_RESP;
            endcase
         end
         ST_BLEND: state_in = ST_WRITE;
         ST_WRITE: state_in = (ev_ff == EV_TICK && check_ff) ? ST_SCAN : ST_RESP;
         ST_SCAN:  if (scan_ff == (IdxW+1)'(NumTasks)) state_in = ST_DONE;
         ST_DONE:  state_in = ST_RESP;
         ST_RESP:  if (rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_RESP);
      rsp_task_valid = out_tv_ff;
      rsp_chosen_task = out_idx_ff;
      rsp_preempt = out_pre_ff;
      we_w = 1'b0;
      wd_w = rd_w;
      addr_w = idx_ff;
      if (state_ff == ST_IDLE) addr_w = (req_mode == EV_TICK) ? cur_ff : req_task_index;
      else if (state_ff == ST_SCAN) addr_w = scan_ff[IdxW-1:0];
      if (state_ff == ST_WRITE) begin
         if (ev_ff == EV_PUT) begin
            we_w = woke_ff;
            wd_w.tau = blend_w;
            wd_w.prio = PrioW'(blend_w);
            wd_w.ticks = '0;
         end else if (ev_ff == EV_TICK) begin
            we_w = 1'b1;
            wd_w.ticks = ticks_new_ff;
            if (check_ff && cfg.sched_mode == SM_EAGER)
               wd_w.prio = PrioW'(blend_w) - PrioW'(cfg.ease_bias);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we_w) mem[addr_w] <= wd_w;
      rd_ff <= mem[addr_w];
      rd_wr_ff <= wr_ff[addr_w];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
      end else if (we_w) begin
         wr_ff[addr_w] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mark_ff <= '0;
         cur_ff <= '0;
         cur_valid_ff <= 1'b0;
         slice_ff <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_IDLE: if (req_valid) begin
               ev_ff <= req_mode;
               woke_ff <= req_woke_up;
               idx_ff <= (req_mode == EV_TICK) ? cur_ff : req_task_index;
               out_tv_ff <= 1'b0;
               out_idx_ff <= '0;
               out_pre_ff <= 1'b0;
               scan_ff <= '0;
               best_valid_ff <= 1'b0;
               check_ff <= 1'b0;
               // untouched entries read as zero until a woken put or a tick writes them
               if (req_mode == EV_PUT) mark_ff[req_task_index] <= 1'b1;
            end
            ST_READ: begin
               ticks_new_ff <= (rd_w.ticks == TimeMax) ? rd_w.ticks
                               : rd_w.ticks + TimeW'(1);
               if (ev_ff == EV_TICK && cur_valid_ff) begin
                  if (slice_ff > 8'd1) slice_ff <= slice_ff - 8'd1;
                  check_ff <= (slice_ff == 8'd1);
               end
            end
            ST_WRITE: begin
               cur_prio_ff <= wd_w.prio;
               scan_ff <= '0;
            end
            ST_SCAN: begin
               if (scan_ff != '0 && scan_hit_w) begin
                  best_valid_ff <= 1'b1;
                  best_idx_ff <= scan_idx_w;
                  best_prio_ff <= rd_w.prio;
               end
               if (scan_ff != (IdxW+1)'(NumTasks)) scan_ff <= scan_ff + (IdxW+1)'(1);
            end
            ST_DONE: begin
               if (ev_ff == EV_GET) begin
                  if (best_valid_ff) begin
                     out_tv_ff <= 1'b1;
                     out_idx_ff <= best_idx_ff;
                     mark_ff[best_idx_ff] <= 1'b0;
                     cur_ff <= best_idx_ff;
                     cur_valid_ff <= 1'b1;
                     slice_ff <= (cfg.sched_mode == SM_PLAIN) ? 8'd0 : cfg.slice_ticks;
                  end
               end else begin
                  out_pre_ff <= best_valid_ff &&
                                ($signed(best_prio_ff) < $signed(cur_prio_ff));
               end
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

// ----- hw/rtl/sjf_burst_predict_scheduler_core.sv -----
// Top level: register file and scheduler core.
//
// Channel | Direction | Ports
// req     | in        | req_valid/req_ready, req_mode, req_task_index, req_woke_up
// rsp     | out       | rsp_valid/rsp_ready, rsp_task_valid, rsp_chosen_task, rsp_preempt
// csr     | in        | csr_psel/penable/pwrite/paddr/pwdata, csr_prdata, csr_pready
//
// A get scans the whole table, and a tick may scan it for a preempting
// task, reading one entry per cycle from the single-port task memory.
// One item is in flight at a time; a stalled result holds the block.
// Synchronous reset clears marks and current task and loads register defaults;
// table entries read as zero until first written.
`timescale 1ns / 1ps
`default_nettype none
module sjf_burst_predict_scheduler_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_mode,
   input  wire logic [5:0]  req_task_index,
   input  wire logic        req_woke_up,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_task_valid,
   output logic [5:0]       rsp_chosen_task,
   output logic             rsp_preempt,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import sjfbp_pkg::*;
   cfg_type cfg_ff;
   reg_addr_type ra_w;

   assign csr_pready = 1'b1;
   assign ra_w = reg_addr_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{sched_mode: SM_EAGER, avg_factor: 8'd64,
                     slice_ticks: 8'd1, ease_bias: 8'd1};
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (ra_w)
            REG_MODE:   cfg_ff.sched_mode <= csr_pwdata[1:0];
            REG_FACTOR: cfg_ff.avg_factor <= csr_pwdata[7:0];
            REG_SLICE:  cfg_ff.slice_ticks <= csr_pwdata[7:0];
            REG_EASE:   cfg_ff.ease_bias <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (ra_w)
         REG_MODE:   csr_prdata = {30'd0, cfg_ff.sched_mode};
         REG_FACTOR: csr_prdata = {24'd0, cfg_ff.avg_factor};
         REG_SLICE:  csr_prdata = {24'd0, cfg_ff.slice_ticks};
         REG_EASE:   csr_prdata = {24'd0, cfg_ff.ease_bias};
         default:    csr_prdata = '0;
      endcase
   end

   sjfbp_ctrl u_ctrl (
      .clock (clock), .reset (reset), .cfg (cfg_ff),
      .req_valid (req_valid), .req_ready (req_ready), .req_mode (req_mode),
      .req_task_index (req_task_index), .req_woke_up (req_woke_up),
      .rsp_valid (rsp_valid), .rsp_ready (rsp_ready),
      .rsp_task_valid (rsp_task_valid), .rsp_chosen_task (rsp_chosen_task),
      .rsp_preempt (rsp_preempt)
   );

   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("accept while result pending");
   a_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_task_valid && rsp_preempt)) else $error("both get and tick fields");
   a_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> req_ready) else $error("no return to idle");
endmodule
`default_nettype wire

// ----- sim/tb_sjf_burst_predict_scheduler_core.sv -----
// Self-checking testbench for the SJF burst-prediction scheduler core.
`timescale 1ns / 1ps
module tb_sjf_burst_predict_scheduler_core;
   import sjfbp_pkg::*;

   typedef struct packed {
      logic [1:0] mode;
      logic [5:0] task_index;
      logic       woke_up;
   } sched_event_type;

   typedef struct packed {
      logic       task_valid;
      logic [5:0] chosen_task;
      logic       preempt;
   } sched_result_type;

   localparam int CycleLimit = 400000;

   logic clock, reset;
   logic req_valid, req_ready, req_woke_up;
   logic [1:0] req_mode;
   logic [5:0] req_task_index;
   logic rsp_valid, rsp_ready, rsp_task_valid, rsp_preempt;
   logic [5:0] rsp_chosen_task;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [3:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   sjf_burst_predict_scheduler_core u_dut (.*);

   // scheduler shadow state
   logic [1:0]        mdl_mode;
   logic [7:0]        mdl_factor, mdl_slice, mdl_ease;
   logic [TimeW-1:0]  mdl_tau[NumTasks];
   logic signed [PrioW-1:0] mdl_prio[NumTasks];
   logic [TimeW-1:0]  mdl_ticks[NumTasks];
   logic              mdl_ready[NumTasks];
   logic [5:0]        mdl_cur;
   logic              mdl_cur_valid;
   logic [7:0]        mdl_slice_left;

   sched_event_type  pending_events[$];
   sched_result_type expected_results[$];
   int mismatches = 0, unexpected = 0, accepted = 0, results_seen = 0, preempts = 0;
   int grants = 0;
   longint cycles = 0;
   bit req_fire = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic logic [TimeW-1:0] avg_burst(logic [TimeW-1:0] tau, logic [TimeW-1:0] t);
      logic [63:0] f, s;
      f = (mdl_factor > 8'd128) ? 64'd128 : 64'(mdl_factor);
      s = 64'(tau) * (64'd128 - f) + 64'(t) * f + 64'd65;
      return TimeW'(s / 64'd128);
   endfunction

   function automatic int least_runnable();
      int best;
      best = -1;
      for (int i = 0; i < NumTasks; i++)
         if (mdl_ready[i] && (best < 0 || mdl_prio[i] < mdl_prio[best])) best = i;
      return best;
   endfunction

   function automatic sched_result_type schedule_event(sched_event_type ev);
      sched_result_type r;
      int best;
      r = '0;
      case (ev.mode)
         EV_PUT: begin
            if (ev.woke_up) begin
               mdl_tau[ev.task_index] = avg_burst(mdl_tau[ev.task_index],
                                                  mdl_ticks[ev.task_index]);
               mdl_prio[ev.task_index] = PrioW'(mdl_tau[ev.task_index]);
               mdl_ticks[ev.task_index] = '0;
            end
            mdl_ready[ev.task_index] = 1'b1;
         end
         EV_GET: begin
            best = least_runnable();
            if (best >= 0) begin
               mdl_ready[best] = 1'b0;
               mdl_cur = 6'(best);
               mdl_cur_valid = 1'b1;
               mdl_slice_left = (mdl_mode == SM_PLAIN) ? 8'd0 : mdl_slice;
               r.task_valid = 1'b1;
               r.chosen_task = 6'(best);
            end
         end
         EV_TICK: begin
            if (mdl_cur_valid) begin
               if (mdl_ticks[mdl_cur] != TimeMax) mdl_ticks[mdl_cur]++;
               if (mdl_slice_left > 8'd1) mdl_slice_left--;
               else if (mdl_slice_left == 8'd1) begin
                  if (mdl_mode == SM_EAGER)
                     mdl_prio[mdl_cur] = $signed({1'b0, avg_burst(mdl_tau[mdl_cur],
                        mdl_ticks[mdl_cur])}) - $signed({17'd0, mdl_ease});
                  best = least_runnable();
                  if (best >= 0 && mdl_prio[best] < mdl_prio[mdl_cur]) r.preempt = 1'b1;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // request driver
   int req_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         // hold beat
      end else if (req_gap > 0) begin
         req_valid <= 1'b0;
         req_gap <= req_gap - 1;
      end else if (pending_events.size() > 0) begin
         sched_event_type ev;
         ev = pending_events.pop_front();
         req_valid <= 1'b1;
         req_mode <= ev.mode;
         req_task_index <= ev.task_index;
         req_woke_up <= ev.woke_up;
         req_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // response stall
   int rsp_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_ready <= 1'b0;
         rsp_gap <= rsp_gap - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_valid && rsp_ready) rsp_gap <= $urandom_range(0, 4);
      end
   end

   // monitor: predict on accepted requests, compare accepted results
   always @(posedge clock) begin
      if (!reset) begin
         req_fire <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            expected_results.push_back(schedule_event({req_mode, req_task_index, req_woke_up}));
            accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            sched_result_type got, want;
            got = {rsp_task_valid, rsp_chosen_task, rsp_preempt};
            results_seen++;
            if (got.task_valid) grants++;
            if (got.preempt) preempts++;
            if (expected_results.size() == 0) begin
               unexpected++;
               if (mismatches + unexpected <= 10) $display("result with none expected: %p", got);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches + unexpected <= 10)
                     $display("mismatch: exp valid=%0d task=%0d pre=%0d, got valid=%0d task=%0d pre=%0d",
                        want.task_valid, want.chosen_task, want.preempt,
                        got.task_valid, got.chosen_task, got.preempt);
               end
            end
         end
      end
   end

   task automatic csr_write(reg_addr_type r, logic [31:0] v);
      @(negedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= 4'(r) * 4'd4; csr_pwdata <= v;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (r)
         REG_MODE:   mdl_mode = v[1:0];
         REG_FACTOR: mdl_factor = v[7:0];
         REG_SLICE:  mdl_slice = v[7:0];
         default:    mdl_ease = v[7:0];
      endcase
   endtask

   task automatic drain();
      while (pending_events.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (NumTasks + 20) @(posedge clock);
   endtask

   task automatic push_event(logic [1:0] m, logic [5:0] idx, logic w);
      sched_event_type ev;
      ev.mode = m; ev.task_index = idx; ev.woke_up = w;
      pending_events.push_back(ev);
   endtask

   // mostly put/get/tick events, ticks the most frequent to build up run time
   task automatic random_phase(int n);
      int roll;
      for (int k = 0; k < n; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 35) push_event(EV_PUT, 6'($urandom), 1'($urandom_range(0, 3) != 0));
         else if (roll < 55) push_event(EV_GET, 6'($urandom), 1'($urandom));
         else if (roll < 97) push_event(EV_TICK, 6'($urandom), 1'($urandom));
         else push_event(EV_NONE, 6'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0; req_mode = '0; req_task_index = '0; req_woke_up = 1'b0;
      rsp_ready = 1'b0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      mdl_mode = SM_EAGER; mdl_factor = 8'd64; mdl_slice = 8'd1; mdl_ease = 8'd1;
      for (int i = 0; i < NumTasks; i++) begin
         mdl_tau[i] = '0; mdl_prio[i] = '0; mdl_ticks[i] = '0; mdl_ready[i] = 1'b0;
      end
      mdl_cur = '0; mdl_cur_valid = 1'b0; mdl_slice_left = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: idle tick, empty get, extremes, repeated put, undefined event
      push_event(EV_TICK, 6'd0, 1'b0);
      push_event(EV_GET, 6'd0, 1'b0);
      push_event(EV_NONE, 6'd63, 1'b1);
      push_event(EV_PUT, 6'd63, 1'b1);
      push_event(EV_PUT, 6'd0, 1'b0);
      push_event(EV_PUT, 6'd0, 1'b0);
      push_event(EV_GET, 6'd0, 1'b0);
      for (int i = 0; i < 5; i++) push_event(EV_TICK, 6'd0, 1'b0);
      push_event(EV_PUT, 6'd0, 1'b1);
      push_event(EV_PUT, 6'd42, 1'b1);
      push_event(EV_GET, 6'd0, 1'b0);
      push_event(EV_PUT, 6'd42, 1'b0);
      push_event(EV_TICK, 6'd0, 1'b0);
      push_event(EV_TICK, 6'd0, 1'b0);
      push_event(EV_GET, 6'd0, 1'b0);
      push_event(EV_GET, 6'd0, 1'b0);
      push_event(EV_TICK, 6'd0, 1'b0);
      drain();

      // settings sweep, extremes included
      csr_write(REG_MODE, SM_PREEMPT); csr_write(REG_FACTOR, 32'd128);
      csr_write(REG_SLICE, 32'd3); csr_write(REG_EASE, 32'd0);
      random_phase(110); drain();
      csr_write(REG_MODE, SM_EAGER); csr_write(REG_FACTOR, 32'd0);
      csr_write(REG_SLICE, 32'd1); csr_write(REG_EASE, 32'd255);
      random_phase(110); drain();
      csr_write(REG_MODE, SM_PLAIN); csr_write(REG_FACTOR, 32'd255);
      csr_write(REG_SLICE, 32'd255);
      random_phase(100); drain();
      csr_write(REG_MODE, SM_RSVD); csr_write(REG_FACTOR, 32'd37);
      csr_write(REG_SLICE, 32'd0); csr_write(REG_EASE, 32'd17);
      random_phase(100); drain();
      csr_write(REG_MODE, SM_EAGER); csr_write(REG_FACTOR, 32'd96);
      csr_write(REG_SLICE, 32'd2); csr_write(REG_EASE, 32'd3);
      random_phase(110); drain();
      csr_write(REG_MODE, SM_PREEMPT); csr_write(REG_SLICE, 32'd1);
      random_phase(110);
      drain();

      $display("%0d requests, %0d results (%0d grants, %0d preempts) over 6 register settings",
               accepted, results_seen, grants, preempts);
      if (mismatches == 0 && unexpected == 0 && expected_results.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
